@@ rtl/core/tkst_pkg.sv @@
// ----------------------------------------------------------------------------
// tkst_pkg
// Shared types, request codes and widths for the top-k sorted insert table.
// ----------------------------------------------------------------------------
package tkst_pkg;

   localparam int DEFAULT_ENTRIES = 5;
   localparam int MAX_ENTRIES     = 16;

   localparam int REQ_TYPE_W   = 2;
   localparam int KEY_W        = 16;
   localparam int NAME_LOW_W   = 64;
   localparam int NAME_HIGH_W  = 16;
   localparam int INDEX_W      = 3;
   localparam int POSITION_W   = 3;
   // wide enough to hold MAX_ENTRIES before masking to the port width
   localparam int POS_CALC_W   = 5;

   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_QUERY  = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ   = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR  = 2'd3;

   typedef struct packed {
      logic signed [KEY_W-1:0]  key;
      logic [NAME_LOW_W-1:0]    name_low;
      logic [NAME_HIGH_W-1:0]   name_high;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      clear;
      entry_type entry;
   } cmd_type;

endpackage

@@ rtl/core/tkst_cell.sv @@
// ----------------------------------------------------------------------------
// tkst_cell
// One slot of the sorted table: compares the broadcast key against its own,
// and on insert either takes its upper neighbor's entry, takes the new one or keeps its own; clear zeroes it.
// ----------------------------------------------------------------------------
module tkst_cell (
   input  logic               clock,
   input  logic               reset,
   input  tkst_pkg::cmd_type  cmd,
   input  tkst_pkg::entry_type prev_entry,
   input  logic               prev_gt,
   output tkst_pkg::entry_type entry,
   output logic               gt
);
   import tkst_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   assign gt = cmd.entry.key > entry_ff.key;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.clear) begin
         entry_in = '0;
      end else if (cmd.insert) begin
         // a slot above already won, so everything from there down moves one place
         if (prev_gt) begin
            entry_in = prev_entry;
         end else if (gt) begin
            entry_in = cmd.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/top_k_sorted_insert_table.sv @@
// ----------------------------------------------------------------------------
// top_k_sorted_insert_table
// Descending table of the best keys with payload, built as a chain of cells.
// ----------------------------------------------------------------------------
// For each request beat every cell compares the new key against its own in
// parallel and the row of cells shifts in the same edge, so a new beat is
// taken every cycle as long as the result beat is taken.
// The result sits in one output register; the request side stalls only while
// that register holds a beat the receiver is stalling. Reset empties the
// table to all-zero keys and payloads at once. Ties rank the new key below.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_table #(
   parameter int ENTRIES = tkst_pkg::DEFAULT_ENTRIES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [tkst_pkg::REQ_TYPE_W-1:0]        req_type,
   input  logic signed [tkst_pkg::KEY_W-1:0]      req_new_score,
   input  logic [tkst_pkg::NAME_LOW_W-1:0]        req_name_low_chars,
   input  logic [tkst_pkg::NAME_HIGH_W-1:0]       req_name_high_chars,
   input  logic [tkst_pkg::INDEX_W-1:0]           req_entry_index,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [tkst_pkg::POSITION_W-1:0]        rsp_position,
   output logic                                   rsp_placed,
   output logic signed [tkst_pkg::KEY_W-1:0]      rsp_entry_score,
   output logic [tkst_pkg::NAME_LOW_W-1:0]        rsp_entry_name_low,
   output logic [tkst_pkg::NAME_HIGH_W-1:0]       rsp_entry_name_high
);
   import tkst_pkg::*;

   localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic                 accept;
   cmd_type              cmd;
   entry_type            cell_entry [ENTRIES];
   logic [ENTRIES-1:0]   cell_gt;
   logic [POS_CALC_W-1:0] pos_full;
   logic [IdxW-1:0]      rd_idx;
   entry_type            rd_entry;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [POSITION_W-1:0] position_ff;
   logic [POSITION_W-1:0] position_in;
   logic                  placed_ff;
   logic                  placed_in;
   entry_type             rd_ff;
   entry_type             rd_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cmd.insert          = accept && (req_type == REQ_INSERT);
   assign cmd.clear           = accept && (req_type == REQ_CLEAR);
   assign cmd.entry.key       = req_new_score;
   assign cmd.entry.name_low  = req_name_low_chars;
   assign cmd.entry.name_high = req_name_high_chars;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         tkst_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_entry ('0),
            .prev_gt    (1'b0),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i])
         );
      end else begin : g_body
         tkst_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .prev_entry (cell_entry[i-1]),
            .prev_gt    (cell_gt[i-1]),
            .entry      (cell_entry[i]),
            .gt         (cell_gt[i])
         );
      end
   end

   // first slot whose key the new key beats; the table stays sorted
   always_comb begin
      pos_full = POS_CALC_W'(ENTRIES);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (cell_gt[i]) begin
            pos_full = POS_CALC_W'(i);
         end
      end
   end

   assign rd_idx = IdxW'(req_entry_index);

   always_comb begin
      rd_entry = '0;
      if (32'(req_entry_index) < ENTRIES) begin
         rd_entry = cell_entry[rd_idx];
      end
   end

   always_comb begin
      position_in = '0;
      placed_in   = 1'b0;
      rd_in       = '0;
      case (req_type)
         REQ_INSERT, REQ_QUERY: begin
            position_in = pos_full[POSITION_W-1:0];
            placed_in   = |cell_gt;
         end
         REQ_READ: begin
            rd_in = rd_entry;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         position_ff <= position_in;
         placed_ff   <= placed_in;
         rd_ff       <= rd_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_position        = position_ff;
   assign rsp_placed          = placed_ff;
   assign rsp_entry_score     = rd_ff.key;
   assign rsp_entry_name_low  = rd_ff.name_low;
   assign rsp_entry_name_high = rd_ff.name_high;

endmodule

@@ rtl/core/tkst_checker.sv @@
// ----------------------------------------------------------------------------
// tkst_checker
// Port-level checks on the sorted table's request and result beats.
// ----------------------------------------------------------------------------
module tkst_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic [tkst_pkg::REQ_TYPE_W-1:0]        req_type,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_placed,
   input logic [tkst_pkg::POSITION_W-1:0]        rsp_position,
   input logic signed [tkst_pkg::KEY_W-1:0]      rsp_entry_score,
   input logic [tkst_pkg::NAME_LOW_W-1:0]        rsp_entry_name_low,
   input logic [tkst_pkg::NAME_HIGH_W-1:0]       rsp_entry_name_high
);
   import tkst_pkg::*;

   // a held result beat stays up until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // every accepted request beat produces a result beat next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request gave no result beat");

   // a placed key comes from insert or query, so no entry payload rides along
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_placed |-> rsp_entry_score == '0
         && rsp_entry_name_low == '0 && rsp_entry_name_high == '0)
      else $error("placed result carries entry data");

   // a clear beat answers with all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_CLEAR |=>
         !rsp_placed && rsp_position == '0 && rsp_entry_score == '0
         && rsp_entry_name_low == '0 && rsp_entry_name_high == '0)
      else $error("clear result not zero");

   // result side is idle right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind top_k_sorted_insert_table tkst_checker u_tkst_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_type            (req_type),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_placed          (rsp_placed),
   .rsp_position        (rsp_position),
   .rsp_entry_score     (rsp_entry_score),
   .rsp_entry_name_low  (rsp_entry_name_low),
   .rsp_entry_name_high (rsp_entry_name_high)
);
